[hw/rtl/cdbc_pkg.sv]
// cdbc_pkg: shared types and constants of the copy descriptor batch coalescer
// holds the entry and batch record types, config register codes and reset values
// depends on nothing
package cdbc_pkg;

    localparam int unsigned MAX_ENTRIES = 65536;
    localparam int unsigned COUNT_FIELD_MAX = 65536;
    localparam int unsigned FULL_AT_INT =
        (MAX_ENTRIES < COUNT_FIELD_MAX) ? MAX_ENTRIES : COUNT_FIELD_MAX;
    localparam logic [16:0] BATCH_FULL_AT = 17'(FULL_AT_INT);

    localparam logic [13:0] STRIDE_RESET = 14'd4;
    localparam logic [31:0] SPAN_LIMIT_RESET = 32'd67108864;

    localparam int unsigned FIFO_DEPTH = 16;
    localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);

    typedef enum logic {
        CFG_ELEMENT_STRIDE   = 1'b0,
        CFG_MERGE_SPAN_LIMIT = 1'b1
    } t_cfg_index;

    // one copy entry turned into byte offsets and range ends
    typedef struct packed {
        logic [31:0] src;
        logic [32:0] src_end;
        logic [31:0] dst;
        logic [32:0] dst_end;
        logic        fin;
    } t_ent;

    typedef struct packed {
        logic [31:0] src_low;
        logic [32:0] src_span;
        logic [31:0] dst_low;
        logic [32:0] dst_span;
        logic [15:0] first_entry;
        logic [16:0] entry_count;
        logic        last_batch;
    } t_batch;

    // up to two batches per entry, packed in order into slot0 then slot1
    typedef struct packed {
        logic   v0;
        t_batch d0;
        logic   v1;
        t_batch d1;
    } t_push;

endpackage

[hw/rtl/cdbc_mul.sv]
// cdbc_mul: three-stage front end, input register, stride multiply, range ends
// turns element indexes into byte offsets, size and 33-bit range ends
// depends on cdbc_pkg
module cdbc_mul
    import cdbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_dest_index,
    input  logic [31:0] i_source_index,
    input  logic [31:0] i_last_element,
    input  logic        i_final_entry,
    input  logic [13:0] i_stride,
    output logic        o_valid,
    output t_ent        o_ent,
    output logic [1:0]  o_inflight
);

    logic        r_v1, r_v2, r_v3;
    logic [31:0] r_didx, r_sidx, r_last;
    logic        r_fin1, r_fin2;
    logic [31:0] r_src, r_dst, r_size;
    t_ent        r_ent;

    logic [31:0] n_src, n_dst, n_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        n_dst  = 32'(r_didx * i_stride);
        n_src  = 32'(r_sidx * i_stride);
        n_size = 32'((r_last + 32'd1) * i_stride);
    end

    always_ff @(posedge i_clk) begin
        r_didx        <= i_dest_index;
        r_sidx        <= i_source_index;
        r_last        <= i_last_element;
        r_fin1        <= i_final_entry;
        r_src         <= n_src;
        r_dst         <= n_dst;
        r_size        <= n_size;
        r_fin2        <= r_fin1;
        r_ent.src     <= r_src;
        r_ent.dst     <= r_dst;
        r_ent.src_end <= {1'b0, r_src} + {1'b0, r_size};
        r_ent.dst_end <= {1'b0, r_dst} + {1'b0, r_size};
        r_ent.fin     <= r_fin2;
    end

    assign o_valid    = r_v3;
    assign o_ent      = r_ent;
    assign o_inflight = 2'({1'b0, r_v1} + {1'b0, r_v2} + {1'b0, r_v3});

endmodule

[hw/rtl/cdbc_merge.sv]
// cdbc_merge: open batch state and the fit check, one entry per cycle
// emits a closed batch and/or the final batch for each entry
// depends on cdbc_pkg
module cdbc_merge
    import cdbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_ent        i_ent,
    input  logic [31:0] i_span_limit,
    output t_push       o_push
);

    logic        r_open;
    logic [31:0] r_src_min, r_dst_min;
    logic [32:0] r_src_max, r_dst_max;
    logic [15:0] r_first, r_pos;
    logic [16:0] r_count;

    logic        n_open;
    logic [31:0] n_src_min, n_dst_min;
    logic [32:0] n_src_max, n_dst_max;
    logic [15:0] n_first, n_pos;
    logic [16:0] n_count;

    logic [31:0] m_src_min, m_dst_min;
    logic [32:0] m_src_max, m_dst_max;
    logic        full, fits, close;
    t_batch      closed_b, final_b;

    always_comb begin
        m_src_min = (i_ent.src < r_src_min) ? i_ent.src : r_src_min;
        m_dst_min = (i_ent.dst < r_dst_min) ? i_ent.dst : r_dst_min;
        m_src_max = (i_ent.src_end > r_src_max) ? i_ent.src_end : r_src_max;
        m_dst_max = (i_ent.dst_end > r_dst_max) ? i_ent.dst_end : r_dst_max;
        full  = (r_count >= BATCH_FULL_AT);
        fits  = !full
              && ((m_src_max - {1'b0, m_src_min}) <= {1'b0, i_span_limit})
              && ((m_dst_max - {1'b0, m_dst_min}) <= {1'b0, i_span_limit});
        close = r_open && !fits;

        closed_b.src_low     = r_src_min;
        closed_b.src_span    = r_src_max - {1'b0, r_src_min};
        closed_b.dst_low     = r_dst_min;
        closed_b.dst_span    = r_dst_max - {1'b0, r_dst_min};
        closed_b.first_entry = r_first;
        closed_b.entry_count = r_count;
        closed_b.last_batch  = 1'b0;

        // merged batch state, or a new batch holding only this entry
        if (r_open && fits) begin
            n_src_min = m_src_min;
            n_src_max = m_src_max;
            n_dst_min = m_dst_min;
            n_dst_max = m_dst_max;
            n_first   = r_first;
            n_count   = r_count + 17'd1;
        end else begin
            n_src_min = i_ent.src;
            n_src_max = i_ent.src_end;
            n_dst_min = i_ent.dst;
            n_dst_max = i_ent.dst_end;
            n_first   = r_pos;
            n_count   = 17'd1;
        end

        final_b.src_low     = n_src_min;
        final_b.src_span    = n_src_max - {1'b0, n_src_min};
        final_b.dst_low     = n_dst_min;
        final_b.dst_span    = n_dst_max - {1'b0, n_dst_min};
        final_b.first_entry = n_first;
        final_b.entry_count = n_count;
        final_b.last_batch  = 1'b1;

        n_open = !i_ent.fin;
        n_pos  = i_ent.fin ? 16'd0 : r_pos + 16'd1;

        o_push.v0 = i_valid && (close || i_ent.fin);
        o_push.d0 = close ? closed_b : final_b;
        o_push.v1 = i_valid && close && i_ent.fin;
        o_push.d1 = final_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open    <= 1'b0;
            r_src_min <= 32'd0;
            r_src_max <= 33'd0;
            r_dst_min <= 32'd0;
            r_dst_max <= 33'd0;
            r_first   <= 16'd0;
            r_count   <= 17'd0;
            r_pos     <= 16'd0;
        end else if (i_valid) begin
            r_open    <= n_open;
            r_src_min <= n_src_min;
            r_src_max <= n_src_max;
            r_dst_min <= n_dst_min;
            r_dst_max <= n_dst_max;
            r_first   <= n_first;
            r_count   <= n_count;
            r_pos     <= n_pos;
        end
    end

endmodule

[hw/rtl/cdbc_fifo.sv]
// cdbc_fifo: result queue in flip-flops, two writes and one read per cycle
// head entry drives the output request and holds while stalled
// depends on cdbc_pkg
module cdbc_fifo
    import cdbc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_push               i_push,
    input  logic                i_pop,
    output logic                o_valid,
    output t_batch              o_head,
    output logic [FIFO_AW:0]    o_count
);

    t_batch             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [FIFO_AW:0]   r_cnt;

    logic [FIFO_AW-1:0] wr1;
    logic [FIFO_AW:0]   n_add;
    logic               pop;

    always_comb begin
        wr1   = r_wr + FIFO_AW'(1);
        n_add = (FIFO_AW+1)'({1'b0, i_push.v0}) + (FIFO_AW+1)'({1'b0, i_push.v1});
        pop   = i_pop && (r_cnt != '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) r_mem[r_wr] <= i_push.d0;
        if (i_push.v1) r_mem[wr1]  <= i_push.d1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + n_add[FIFO_AW-1:0];
            if (pop) r_rd <= r_rd + FIFO_AW'(1);
            r_cnt <= r_cnt + n_add - (FIFO_AW+1)'({1'b0, pop});
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign o_count = r_cnt;

endmodule

[hw/rtl/copy_descriptor_batch_coalescer_core.sv]
// copy_descriptor_batch_coalescer_core: top level, config registers and credit
// check in front of the entry pipeline, merge stage and result queue
// depends on cdbc_pkg, cdbc_mul, cdbc_merge, cdbc_fifo
//
// Usage:
//   Input channel: i_in_valid with o_in_stall carries one copy entry per
//   request (dest_index, source_index, last_element, final_entry).
//   Output channel: o_out_valid with i_out_stall carries one batch per request.
//   Config: i_cfg_we writes i_cfg_data into register i_cfg_index (0 stride,
//   1 merge span limit) at the clock edge; write only while the block is idle.
//   Throughput: one entry per cycle while o_in_stall is low. An entry
//   yields zero, one or two batches; the output side takes one batch a
//   cycle while i_out_stall is low, so entries that yield two slow the
//   input down through o_in_stall.
//   Path: an accepted entry passes the input register, multiply and range
//   ends stages; the merge then writes its batches into the queue.
//   o_in_stall rises when the 16-entry result queue could not take two
//   batches from every entry in flight plus one more.
//   Stall: while i_out_stall is high the head batch holds; the queue fills and
//   then the input is stalled. Nothing is dropped.
//   Reset: synchronous, active low; queue empties, no batch is open, stride
//   returns to 4 and span limit to 64 MiB.
module copy_descriptor_batch_coalescer_core
    import cdbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_dest_index,
    input  logic [31:0] i_source_index,
    input  logic [31:0] i_last_element,
    input  logic        i_final_entry,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_src_low,
    output logic [32:0] o_src_span,
    output logic [31:0] o_dst_low,
    output logic [32:0] o_dst_span,
    output logic [15:0] o_first_entry,
    output logic [16:0] o_entry_count,
    output logic        o_last_batch
);

    logic [13:0]      r_stride;
    logic [31:0]      r_span_limit;
    logic             in_full;

    logic             ent_valid;
    t_ent             ent;
    logic [1:0]       inflight;
    t_push            push;
    t_batch           head;
    logic [FIFO_AW:0] q_count;
    logic [FIFO_AW+2:0] need;
    logic             accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride     <= STRIDE_RESET;
            r_span_limit <= SPAN_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ELEMENT_STRIDE:   r_stride     <= i_cfg_data[13:0];
                CFG_MERGE_SPAN_LIMIT: r_span_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // worst case two batches per entry in flight plus the one being accepted
    always_comb begin
        need = (FIFO_AW+3)'(q_count) + (FIFO_AW+3)'({inflight, 1'b0})
             + (FIFO_AW+3)'(2);
        in_full = (need > (FIFO_AW+3)'(FIFO_DEPTH));
        accept = i_in_valid && !in_full;
    end

    assign o_in_stall = in_full;

    cdbc_mul u_mul (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (accept),
        .i_dest_index   (i_dest_index),
        .i_source_index (i_source_index),
        .i_last_element (i_last_element),
        .i_final_entry  (i_final_entry),
        .i_stride       (r_stride),
        .o_valid        (ent_valid),
        .o_ent          (ent),
        .o_inflight     (inflight)
    );

    cdbc_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (ent_valid),
        .i_ent        (ent),
        .i_span_limit (r_span_limit),
        .o_push       (push)
    );

    cdbc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_out_stall),
        .o_valid (o_out_valid),
        .o_head  (head),
        .o_count (q_count)
    );

    assign o_src_low     = head.src_low;
    assign o_src_span    = head.src_span;
    assign o_dst_low     = head.dst_low;
    assign o_dst_span    = head.dst_span;
    assign o_first_entry = head.first_entry;
    assign o_entry_count = head.entry_count;
    assign o_last_batch  = head.last_batch;

endmodule

[tb/copy_descriptor_batch_coalescer_core_test.sv]
// copy_descriptor_batch_coalescer_core_test: self-checking testbench for the copy batch coalescer
// drives copy entries and config writes, predicts every batch and checks results in order
// depends on cdbc_pkg and copy_descriptor_batch_coalescer_core
module copy_descriptor_batch_coalescer_core_test;
    import cdbc_pkg::*;

    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned REPORT_MAX = 30;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CONFIG_EVERY = 125;
    localparam int unsigned FINAL_PCT = 10;
    localparam int unsigned ZERO_RUN = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_dest_index;
    logic [31:0] i_source_index;
    logic [31:0] i_last_element;
    logic        i_final_entry;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_src_low;
    logic [32:0] o_src_span;
    logic [31:0] o_dst_low;
    logic [32:0] o_dst_span;
    logic [15:0] o_first_entry;
    logic [16:0] o_entry_count;
    logic        o_last_batch;

    // predictor copy of the registers and the open batch
    logic [13:0] stride_cfg = STRIDE_RESET;
    logic [31:0] span_limit_cfg = SPAN_LIMIT_RESET;
    logic        batch_is_open = 1'b0;
    logic [31:0] src_lo = '0;
    logic [32:0] src_hi = '0;
    logic [31:0] dst_lo = '0;
    logic [32:0] dst_hi = '0;
    logic [15:0] open_first_pos = '0;
    logic [16:0] merged_count = '0;
    logic [15:0] dispatch_pos = '0;

    t_batch      pending_batches[$];
    t_batch      want_batch;
    int unsigned entries_sent = 0;
    int unsigned batches_seen = 0;
    int unsigned errors = 0;
    int unsigned quiet_cycles = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    logic [31:0] dst_base = '0;
    logic [31:0] src_base = '0;

    copy_descriptor_batch_coalescer_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_dest_index   (i_dest_index),
        .i_source_index (i_source_index),
        .i_last_element (i_last_element),
        .i_final_entry  (i_final_entry),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_src_low      (o_src_low),
        .o_src_span     (o_src_span),
        .o_dst_low      (o_dst_low),
        .o_dst_span     (o_dst_span),
        .o_first_entry  (o_first_entry),
        .o_entry_count  (o_entry_count),
        .o_last_batch   (o_last_batch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic t_batch close_batch(input logic last);
        t_batch b;
        b.src_low     = src_lo;
        b.src_span    = src_hi - {1'b0, src_lo};
        b.dst_low     = dst_lo;
        b.dst_span    = dst_hi - {1'b0, dst_lo};
        b.first_entry = open_first_pos;
        b.entry_count = merged_count;
        b.last_batch  = last;
        return b;
    endfunction

    // turn one accepted entry into byte ranges and merge or split the open batch
    task automatic predict_entry(input logic [31:0] d_idx, input logic [31:0] s_idx,
                                 input logic [31:0] last_el, input logic fin);
        logic [31:0] stride32;
        logic [31:0] d_off;
        logic [31:0] s_off;
        logic [31:0] size;
        logic [31:0] s_lo;
        logic [31:0] d_lo;
        logic [32:0] s_end;
        logic [32:0] d_end;
        logic [32:0] s_hi;
        logic [32:0] d_hi;
        logic        fits;
        stride32 = {18'd0, stride_cfg};
        d_off = d_idx * stride32;
        s_off = s_idx * stride32;
        size  = (last_el + 32'd1) * stride32;
        s_end = {1'b0, s_off} + {1'b0, size};
        d_end = {1'b0, d_off} + {1'b0, size};
        fits  = 1'b0;
        s_lo  = (s_off < src_lo) ? s_off : src_lo;
        s_hi  = (s_end > src_hi) ? s_end : src_hi;
        d_lo  = (d_off < dst_lo) ? d_off : dst_lo;
        d_hi  = (d_end > dst_hi) ? d_end : dst_hi;
        if (batch_is_open) begin
            fits = (merged_count < BATCH_FULL_AT)
                && ((s_hi - {1'b0, s_lo}) <= {1'b0, span_limit_cfg})
                && ((d_hi - {1'b0, d_lo}) <= {1'b0, span_limit_cfg});
        end
        if (fits) begin
            src_lo = s_lo;
            src_hi = s_hi;
            dst_lo = d_lo;
            dst_hi = d_hi;
            merged_count = merged_count + 17'd1;
        end else begin
            if (batch_is_open) begin
                pending_batches.push_back(close_batch(1'b0));
            end
            batch_is_open = 1'b1;
            src_lo = s_off;
            src_hi = s_end;
            dst_lo = d_off;
            dst_hi = d_end;
            open_first_pos = dispatch_pos;
            merged_count = 17'd1;
        end
        dispatch_pos = dispatch_pos + 16'd1;
        if (fin) begin
            pending_batches.push_back(close_batch(1'b1));
            batch_is_open = 1'b0;
            dispatch_pos = '0;
        end
        entries_sent++;
    endtask

    task automatic report_mismatch(input string what, input logic [32:0] got,
                                   input logic [32:0] want);
        errors++;
        if (errors <= REPORT_MAX) begin
            $display("mismatch on batch %0d: %s got 0x%0h expected 0x%0h",
                     batches_seen, what, got, want);
        end
    endtask

    task automatic check_field(input string what, input logic [32:0] got,
                               input logic [32:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            batches_seen++;
            if (pending_batches.size() == 0) begin
                report_mismatch("batch with none expected", 33'(o_src_low), '0);
            end else begin
                want_batch = pending_batches.pop_front();
                check_field("src_low", 33'(o_src_low), 33'(want_batch.src_low));
                check_field("src_span", o_src_span, want_batch.src_span);
                check_field("dst_low", 33'(o_dst_low), 33'(want_batch.dst_low));
                check_field("dst_span", o_dst_span, want_batch.dst_span);
                check_field("first_entry", 33'(o_first_entry), 33'(want_batch.first_entry));
                check_field("entry_count", 33'(o_entry_count), 33'(want_batch.entry_count));
                check_field("last_batch", 33'(o_last_batch), 33'(want_batch.last_batch));
            end
        end
    end

    // watchdog: nothing accepted on either channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog expired with %0d batches outstanding",
                         pending_batches.size());
                $display("copy_descriptor_batch_coalescer_core regression: fail");
                $finish;
            end
        end
    end

    // returns at a falling edge with valid still high; the caller lowers it if nothing follows
    task automatic send_entry(input logic [31:0] d_idx, input logic [31:0] s_idx,
                              input logic [31:0] last_el, input logic fin);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_dest_index   = d_idx;
        i_source_index = s_idx;
        i_last_element = last_el;
        i_final_entry  = fin;
        i_in_valid     = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_entry(d_idx, s_idx, last_el, fin);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] data);
        i_in_valid  = 1'b0;
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        if (idx == CFG_ELEMENT_STRIDE) begin
            stride_cfg = data[13:0];
        end else begin
            span_limit_cfg = data;
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // entries without a result may still be in the pipe once the queue is empty
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (pending_batches.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic pick_config();
        logic [13:0] st;
        logic [31:0] lim;
        int unsigned k;
        k = $urandom_range(0, 9);
        st = (k == 0) ? 14'd0 : (k <= 2) ? 14'd1 : (k <= 4) ? 14'h3FFF
           : 14'($urandom_range(1, 16383));
        // upper data bits are don't care for the stride
        write_reg(CFG_ELEMENT_STRIDE, ($urandom & 32'hFFFF_C000) | {18'd0, st});
        k = $urandom_range(0, 9);
        lim = (k == 0) ? 32'd0 : (k == 1) ? 32'hFFFF_FFFF : (k == 2) ? SPAN_LIMIT_RESET
            : (k <= 8) ? {18'd0, st} * $urandom_range(0, 512) : $urandom;
        write_reg(CFG_MERGE_SPAN_LIMIT, lim);
    endtask

    // mostly clustered indices so batches grow, with jumps and full-range noise
    task automatic send_random_entry();
        logic [31:0] d_idx;
        logic [31:0] s_idx;
        logic [31:0] last_el;
        int unsigned mode;
        mode = $urandom_range(0, 99);
        if (mode < 12) begin
            dst_base = $urandom;
            src_base = $urandom;
        end
        if (mode < 75) begin
            d_idx   = dst_base + $urandom_range(0, 63);
            s_idx   = src_base + $urandom_range(0, 63);
            last_el = $urandom_range(0, 31);
        end else if (mode < 90) begin
            d_idx   = $urandom;
            s_idx   = $urandom;
            last_el = $urandom_range(0, 4095);
        end else begin
            d_idx   = $urandom;
            s_idx   = $urandom;
            last_el = (mode >= 97) ? 32'hFFFF_FFFF : $urandom;
        end
        send_entry(d_idx, s_idx, last_el, $urandom_range(0, 99) < FINAL_PCT);
    endtask

    task automatic test_reset_values();
        // reset stride and span limit; the third entry lands 64 MiB away and splits
        send_entry(32'd0, 32'd0, 32'd0, 1'b0);
        send_entry(32'd1, 32'd1, 32'd0, 1'b0);
        send_entry(32'h0100_0000, 32'd2, 32'd0, 1'b0);
        // stays within 64 MiB of the open batch, merges and is final
        send_entry(32'd3, 32'd3, 32'd7, 1'b1);
    endtask

    task automatic test_field_extremes();
        wait_idle();
        write_reg(CFG_ELEMENT_STRIDE, 32'hFFFF_FFFF);
        write_reg(CFG_MERGE_SPAN_LIMIT, 32'hFFFF_FFFF);
        // all-ones last element wraps the size to zero
        send_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_entry(32'd0, 32'd0, 32'd0, 1'b0);
        send_entry(32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 1'b0);
        send_entry(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_stride_zero();
        wait_idle();
        write_reg(CFG_ELEMENT_STRIDE, 32'hFFFF_C000);
        write_reg(CFG_MERGE_SPAN_LIMIT, 32'd0);
        // every offset and size collapses to zero, so all three merge
        send_entry($urandom, $urandom, $urandom, 1'b0);
        send_entry($urandom, $urandom, $urandom, 1'b0);
        send_entry($urandom, $urandom, $urandom, 1'b1);
    endtask

    task automatic test_span_boundary();
        wait_idle();
        write_reg(CFG_ELEMENT_STRIDE, 32'd1);
        write_reg(CFG_MERGE_SPAN_LIMIT, 32'd8);
        send_entry(32'd0, 32'd0, 32'd3, 1'b0);
        // span exactly at the limit still merges
        send_entry(32'd4, 32'd4, 32'd3, 1'b0);
        send_entry(32'd5, 32'd5, 32'd3, 1'b1);
        // only the source range overflows
        send_entry(32'd0, 32'd0, 32'd0, 1'b0);
        send_entry(32'd1, 32'd40, 32'd0, 1'b1);
    endtask

    task automatic test_config_mid_batch();
        wait_idle();
        write_reg(CFG_ELEMENT_STRIDE, 32'd4);
        write_reg(CFG_MERGE_SPAN_LIMIT, 32'hFFFF_FFFF);
        send_entry(32'd10, 32'd10, 32'd0, 1'b0);
        send_entry(32'd11, 32'd11, 32'd0, 1'b0);
        // batch stays open across the writes; merged ranges are kept
        wait_idle();
        write_reg(CFG_ELEMENT_STRIDE, 32'd8);
        write_reg(CFG_MERGE_SPAN_LIMIT, SPAN_LIMIT_RESET);
        send_entry(32'd12, 32'd12, 32'd0, 1'b0);
        send_entry(32'd20, 32'd20, 32'd1, 1'b1);
    endtask

    task automatic test_zero_limit_merge();
        wait_idle();
        idle_pct  = 0;
        stall_pct = 0;
        write_reg(CFG_ELEMENT_STRIDE, 32'd1);
        write_reg(CFG_MERGE_SPAN_LIMIT, 32'd0);
        // the lone first batch shifts the long one off position zero
        send_entry(32'd100, 32'd100, 32'hFFFF_FFFF, 1'b0);
        // zero-size entries at one offset keep merging under a zero span limit
        for (int n = 0; n < ZERO_RUN; n++) begin
            send_entry(32'd0, 32'd0, 32'hFFFF_FFFF, n == ZERO_RUN - 1);
        end
    endtask

    task automatic test_random_traffic(input int unsigned send_idle, input int unsigned recv_stall,
                                       input int unsigned count);
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        for (int i = 0; i < count; i++) begin
            if (i % CONFIG_EVERY == 0) begin
                wait_idle();
                pick_config();
            end
            send_random_entry();
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_ELEMENT_STRIDE;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_dest_index   = '0;
        i_source_index = '0;
        i_last_element = '0;
        i_final_entry  = 1'b0;
        i_out_stall    = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_values();
        test_field_extremes();
        test_stride_zero();
        test_span_boundary();
        test_config_mid_batch();
        test_zero_limit_merge();
        test_random_traffic(0, 0, 375);
        test_random_traffic(77, 0, 375);
        test_random_traffic(0, 77, 375);
        test_random_traffic(38, 38, 375);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("covered %0d copy entries and %0d batches: directed cases, a zero-limit run,",
                 entries_sent, batches_seen);
        $display("random traffic under four idle and stall profiles; %0d mismatches", errors);
        if (errors == 0 && pending_batches.size() == 0) begin
            $display("copy_descriptor_batch_coalescer_core regression: pass");
        end else begin
            $display("copy_descriptor_batch_coalescer_core regression: fail");
        end
        $finish;
    end

endmodule
